// ===== rtl/core/ddm_pkg.sv =====
// shared types, constants and helpers of the differential drive duty mixer
`timescale 1ns / 1ps
package ddm_pkg;

  localparam int SPEED_W    = 7;
  localparam int STEER_W    = 8;
  localparam int DUTY_W     = 8;
  localparam int PCT_W      = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  localparam int DUTY_FULL  = 100;
  localparam int DUTY_HALF  = 50;
  localparam int RECIP_100  = 5243;
  localparam int RECIP_SH   = 19;
  localparam int PROD_W     = 14;
  localparam int RECIP_W    = 26;

  // mixed side range -100..200
  localparam int MIX_W      = 9;
  localparam int MAG_W      = 8;

  localparam int QDEPTH     = 2;
  localparam int QAW        = $clog2(QDEPTH);
  localparam int QCW        = $clog2(QDEPTH + 1);

  localparam logic [PCT_W-1:0] MAX_DUTY_RST   = PCT_W'(DUTY_FULL);
  localparam logic [PCT_W-1:0] MIN_DUTY_RST   = '0;
  localparam logic [PCT_W-1:0] STEER_GAIN_RST = PCT_W'(DUTY_FULL);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_DUTY,
    REG_MIN_DUTY,
    REG_STEER_GAIN,
    REG_PIVOT_ENABLE,
    REG_FLIP_LEFT,
    REG_FLIP_RIGHT
  } reg_idx_t;

  typedef struct packed {
    logic [PCT_W-1:0] top;
    logic [PCT_W-1:0] floor_duty;
    logic [PCT_W-1:0] span;
    logic [PCT_W-1:0] gain;
    logic             pivot;
    logic             flip_l;
    logic             flip_r;
  } ddm_cfg_t;

  typedef struct packed {
    logic             stop;
    logic             rescale;
    logic             neg_l;
    logic             neg_r;
    logic [MAG_W-1:0] mag_l;
    logic [MAG_W-1:0] mag_r;
    logic [MAG_W-1:0] peak;
  } ddm_cmd_t;

  function automatic logic [MAG_W-1:0] mag_of(logic signed [MIX_W-1:0] v);
    logic signed [MIX_W-1:0] n;
    n = -v;
    return v[MIX_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
  endfunction

endpackage

// ===== rtl/core/ddm_ifs.sv =====
// request, result and register write channels of the duty mixer
`timescale 1ns / 1ps
interface ddm_in_if;
  import ddm_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [SPEED_W-1:0]        speed;
  logic signed [STEER_W-1:0] steer;
  modport source (output valid, output speed, output steer, input ready);
  modport sink (input valid, input speed, input steer, output ready);
endinterface

interface ddm_out_if;
  import ddm_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DUTY_W-1:0] left_duty;
  logic signed [DUTY_W-1:0] right_duty;
  modport source (output valid, output left_duty, output right_duty, input ready);
  modport sink (input valid, input left_duty, input right_duty, output ready);
endinterface

interface ddm_cfg_if;
  import ddm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/differential_drive_duty_mixer.sv =====
// top level of the differential drive duty mixer: registers, front, queue, back
//
//   channel   dir  fields                       handshake
//   in_chan   in   speed[6:0], steer[7:0] s     valid / ready
//   out_chan  out  left_duty[7:0] s, right_duty  valid / ready
//   cfg_chan  in   index[2:0], data[6:0]        valid / ready, ready tied high
//
// one request per cycle sustained while the result side is not stalled; a request passes
// through the two-stage turn pipe, the queue slot, the rescale divider and the three
// stages of duty compression
// rst_n clears all valid flags and loads register defaults, no clearing pass
// a stalled result holds the back end; the front keeps going until the queue fills
`timescale 1ns / 1ps
module differential_drive_duty_mixer (
  input  logic       clk,
  input  logic       rst_n,
  ddm_in_if.sink     in_chan,
  ddm_out_if.source  out_chan,
  ddm_cfg_if.sink    cfg_chan
);
  import ddm_pkg::*;

  logic [PCT_W-1:0] max_duty_r;
  logic [PCT_W-1:0] min_duty_r;
  logic [PCT_W-1:0] steer_gain_r;
  logic             pivot_r;
  logic             flip_l_r;
  logic             flip_r_r;

  ddm_cfg_t         cfg;
  logic [PCT_W-1:0] top;

  logic             push_valid;
  logic             push_ready;
  ddm_cmd_t         push_data;
  logic             pop_valid;
  logic             pop_ready;
  ddm_cmd_t         pop_data;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_duty_r   <= MAX_DUTY_RST;
      min_duty_r   <= MIN_DUTY_RST;
      steer_gain_r <= STEER_GAIN_RST;
      pivot_r      <= 1'b0;
      flip_l_r     <= 1'b0;
      flip_r_r     <= 1'b0;
    end else if (cfg_chan.valid) begin
      case (reg_idx_t'(cfg_chan.index))
        REG_MAX_DUTY:     max_duty_r   <= cfg_chan.data;
        REG_MIN_DUTY:     min_duty_r   <= cfg_chan.data;
        REG_STEER_GAIN:   steer_gain_r <= cfg_chan.data;
        REG_PIVOT_ENABLE: pivot_r      <= cfg_chan.data[0];
        REG_FLIP_LEFT:    flip_l_r     <= cfg_chan.data[0];
        REG_FLIP_RIGHT:   flip_r_r     <= cfg_chan.data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    top            = (max_duty_r > PCT_W'(DUTY_FULL)) ? PCT_W'(DUTY_FULL) : max_duty_r;
    cfg.top        = top;
    cfg.floor_duty = (min_duty_r > top) ? top : min_duty_r;
    cfg.span       = top - cfg.floor_duty;
    cfg.gain       = (steer_gain_r > PCT_W'(DUTY_FULL)) ? PCT_W'(DUTY_FULL) : steer_gain_r;
    cfg.pivot      = pivot_r;
    cfg.flip_l     = flip_l_r;
    cfg.flip_r     = flip_r_r;
  end

  ddm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  ddm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  ddm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_chan  (out_chan)
  );

endmodule

// ===== rtl/core/ddm_front.sv =====
// front: request intake, saturation, turn and mixing of both sides
`timescale 1ns / 1ps
module ddm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  ddm_pkg::ddm_cfg_t cfg,
  ddm_in_if.sink            in_chan,
  output logic              push_valid,
  input  logic              push_ready,
  output ddm_pkg::ddm_cmd_t push_data
);
  import ddm_pkg::*;

  logic                      en;
  logic [PCT_W-1:0]          spd_sat;
  logic signed [STEER_W-1:0] str_sat;
  logic signed [STEER_W-1:0] str_neg;
  logic [PCT_W-1:0]          str_mag;

  logic                      f1_vld_r;
  logic                      f1_stop_r;
  logic                      f1_neg_r;
  logic [PCT_W-1:0]          f1_spd_r;
  logic [PROD_W-1:0]         f1_prod_r;

  logic                      f2_vld_r;
  logic                      f2_stop_r;
  logic                      f2_neg_r;
  logic [PCT_W-1:0]          f2_spd_r;
  logic [RECIP_W-1:0]        f2_recip_r;

  logic [PCT_W-1:0]          turn_mag;
  logic signed [MIX_W-1:0]   turn;
  logic signed [MIX_W-1:0]   left;
  logic signed [MIX_W-1:0]   right;
  logic [MAG_W-1:0]          mag_l;
  logic [MAG_W-1:0]          mag_r;
  logic [MAG_W-1:0]          peak;

  assign en            = !f2_vld_r || push_ready;
  assign in_chan.ready = en;

  always_comb begin
    spd_sat = (in_chan.speed > SPEED_W'(DUTY_FULL)) ? PCT_W'(DUTY_FULL) : in_chan.speed;
    if (in_chan.steer > STEER_W'(DUTY_FULL)) begin
      str_sat = STEER_W'(DUTY_FULL);
    end else if (in_chan.steer < -STEER_W'(DUTY_FULL)) begin
      str_sat = -STEER_W'(DUTY_FULL);
    end else begin
      str_sat = in_chan.steer;
    end
    str_neg = -str_sat;
    str_mag = str_sat[STEER_W-1] ? str_neg[PCT_W-1:0] : str_sat[PCT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
      f2_vld_r <= 1'b0;
    end else if (en) begin
      f1_vld_r <= in_chan.valid;
      f2_vld_r <= f1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_stop_r  <= (spd_sat == '0) && !cfg.pivot;
      f1_neg_r   <= str_sat[STEER_W-1];
      f1_spd_r   <= spd_sat;
      f1_prod_r  <= PROD_W'(str_mag) * PROD_W'(cfg.gain);
      f2_stop_r  <= f1_stop_r;
      f2_neg_r   <= f1_neg_r;
      f2_spd_r   <= f1_spd_r;
      f2_recip_r <= RECIP_W'(f1_prod_r + PROD_W'(DUTY_HALF)) * RECIP_W'(RECIP_100);
    end
  end

  always_comb begin
    turn_mag = f2_recip_r[RECIP_SH +: PCT_W];
    turn     = f2_neg_r ? -$signed(MIX_W'(turn_mag)) : $signed(MIX_W'(turn_mag));
    left     = $signed(MIX_W'(f2_spd_r)) + turn;
    right    = $signed(MIX_W'(f2_spd_r)) - turn;
    mag_l    = mag_of(left);
    mag_r    = mag_of(right);
    peak     = (mag_l > mag_r) ? mag_l : mag_r;
  end

  assign push_valid        = f2_vld_r;
  assign push_data.stop    = f2_stop_r;
  assign push_data.rescale = peak > MAG_W'(DUTY_FULL);
  assign push_data.neg_l   = left[MIX_W-1];
  assign push_data.neg_r   = right[MIX_W-1];
  assign push_data.mag_l   = mag_l;
  assign push_data.mag_r   = mag_r;
  assign push_data.peak    = peak;

endmodule

// ===== rtl/core/ddm_queue.sv =====
// short queue between front and back
`timescale 1ns / 1ps
module ddm_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  ddm_pkg::ddm_cmd_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output ddm_pkg::ddm_cmd_t pop_data
);
  import ddm_pkg::*;

  ddm_cmd_t         mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r;
  logic [QAW-1:0]   rd_ptr_r;
  logic [QCW-1:0]   count_r;
  logic [QAW-1:0]   wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_nxt;
  logic [QCW-1:0]   count_nxt;
  logic             push_fire;
  logic             pop_fire;

  assign push_ready = count_r != QCW'(QDEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_fire) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_fire) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_fire && !pop_fire) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_fire && !push_fire) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCW'(QDEPTH))
    else $error("queue count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push_fire && !pop_fire) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count missed a push");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_fire && !push_fire) |=> count_r == $past(count_r) - 1'b1)
    else $error("queue count missed a pop");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == QCW'(QDEPTH)) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers disagree with count");

endmodule

// ===== rtl/core/ddm_back.sv =====
// back: peak rescale divider, duty compression, flips and result register
`timescale 1ns / 1ps
module ddm_back (
  input  logic              clk,
  input  logic              rst_n,
  input  ddm_pkg::ddm_cfg_t cfg,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  ddm_pkg::ddm_cmd_t pop_data,
  ddm_out_if.source         out_chan
);
  import ddm_pkg::*;

  localparam int NUM_W = 15;
  localparam int QBITS = 7;

  typedef struct packed {
    logic             stop;
    logic             rescale;
    logic             neg_l;
    logic             neg_r;
    logic [MAG_W-1:0] mag_l;
    logic [MAG_W-1:0] mag_r;
    logic [MAG_W-1:0] peak;
    logic [NUM_W-1:0] rem_l;
    logic [NUM_W-1:0] rem_r;
    logic [QBITS-1:0] q_l;
    logic [QBITS-1:0] q_r;
  } div_t;

  function automatic div_t div_step(div_t s, logic [2:0] b);
    div_t             r;
    logic [NUM_W-1:0] d;
    r = s;
    d = NUM_W'(s.peak) << b;
    if (s.rem_l >= d) begin
      r.rem_l  = s.rem_l - d;
      r.q_l[b] = 1'b1;
    end
    if (s.rem_r >= d) begin
      r.rem_r  = s.rem_r - d;
      r.q_r[b] = 1'b1;
    end
    return r;
  endfunction

  logic               en;
  div_t               dv_r [QBITS+1];
  logic [QBITS:0]     dv_vld_r;
  div_t               dv_in;
  div_t               dv_nxt [QBITS];

  logic [PCT_W-1:0]   m_l;
  logic [PCT_W-1:0]   m_r;
  logic               ms_vld_r;
  logic               ms_neg_l_r;
  logic               ms_neg_r_r;
  logic               ms_zero_l_r;
  logic               ms_zero_r_r;
  logic [PROD_W-1:0]  ms_prod_l_r;
  logic [PROD_W-1:0]  ms_prod_r_r;

  logic               rs_vld_r;
  logic               rs_neg_l_r;
  logic               rs_neg_r_r;
  logic               rs_zero_l_r;
  logic               rs_zero_r_r;
  logic [RECIP_W-1:0] rs_recip_l_r;
  logic [RECIP_W-1:0] rs_recip_r_r;

  logic [PCT_W-1:0]   d_l;
  logic [PCT_W-1:0]   d_r;
  logic signed [DUTY_W-1:0] duty_l;
  logic signed [DUTY_W-1:0] duty_r;

  logic               out_vld_r;
  logic signed [DUTY_W-1:0] out_l_r;
  logic signed [DUTY_W-1:0] out_r_r;

  assign en        = !out_vld_r || out_chan.ready;
  assign pop_ready = en;

  always_comb begin
    dv_in.stop    = pop_data.stop;
    dv_in.rescale = pop_data.rescale;
    dv_in.neg_l   = pop_data.neg_l;
    dv_in.neg_r   = pop_data.neg_r;
    dv_in.mag_l   = pop_data.mag_l;
    dv_in.mag_r   = pop_data.mag_r;
    dv_in.peak    = pop_data.peak;
    dv_in.rem_l   = NUM_W'(pop_data.mag_l) * NUM_W'(DUTY_FULL) + NUM_W'(pop_data.peak[MAG_W-1:1]);
    dv_in.rem_r   = NUM_W'(pop_data.mag_r) * NUM_W'(DUTY_FULL) + NUM_W'(pop_data.peak[MAG_W-1:1]);
    dv_in.q_l     = '0;
    dv_in.q_r     = '0;
    for (int k = 0; k < QBITS; k++) begin
      dv_nxt[k] = div_step(dv_r[k], 3'(QBITS - 1 - k));
    end
  end

  always_comb begin
    m_l = dv_r[QBITS].rescale ? dv_r[QBITS].q_l : dv_r[QBITS].mag_l[PCT_W-1:0];
    m_r = dv_r[QBITS].rescale ? dv_r[QBITS].q_r : dv_r[QBITS].mag_r[PCT_W-1:0];
  end

  always_comb begin
    d_l    = cfg.floor_duty + rs_recip_l_r[RECIP_SH +: PCT_W];
    d_r    = cfg.floor_duty + rs_recip_r_r[RECIP_SH +: PCT_W];
    duty_l = (rs_neg_l_r ^ cfg.flip_l) ? -$signed(DUTY_W'(d_l)) : $signed(DUTY_W'(d_l));
    duty_r = (rs_neg_r_r ^ cfg.flip_r) ? -$signed(DUTY_W'(d_r)) : $signed(DUTY_W'(d_r));
    if (rs_zero_l_r) begin
      duty_l = '0;
    end
    if (rs_zero_r_r) begin
      duty_r = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r  <= '0;
      ms_vld_r  <= 1'b0;
      rs_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      dv_vld_r  <= {dv_vld_r[QBITS-1:0], pop_valid};
      ms_vld_r  <= dv_vld_r[QBITS];
      rs_vld_r  <= ms_vld_r;
      out_vld_r <= rs_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0] <= dv_in;
      for (int k = 0; k < QBITS; k++) begin
        dv_r[k+1] <= dv_nxt[k];
      end
      ms_neg_l_r   <= dv_r[QBITS].neg_l;
      ms_neg_r_r   <= dv_r[QBITS].neg_r;
      ms_zero_l_r  <= dv_r[QBITS].stop || (m_l == '0);
      ms_zero_r_r  <= dv_r[QBITS].stop || (m_r == '0);
      ms_prod_l_r  <= PROD_W'(m_l) * PROD_W'(cfg.span);
      ms_prod_r_r  <= PROD_W'(m_r) * PROD_W'(cfg.span);
      rs_neg_l_r   <= ms_neg_l_r;
      rs_neg_r_r   <= ms_neg_r_r;
      rs_zero_l_r  <= ms_zero_l_r;
      rs_zero_r_r  <= ms_zero_r_r;
      rs_recip_l_r <= RECIP_W'(ms_prod_l_r + PROD_W'(DUTY_HALF)) * RECIP_W'(RECIP_100);
      rs_recip_r_r <= RECIP_W'(ms_prod_r_r + PROD_W'(DUTY_HALF)) * RECIP_W'(RECIP_100);
      out_l_r      <= duty_l;
      out_r_r      <= duty_r;
    end
  end

  assign out_chan.valid      = out_vld_r;
  assign out_chan.left_duty  = out_l_r;
  assign out_chan.right_duty = out_r_r;

endmodule

// ===== bench/differential_drive_duty_mixer_test.sv =====
// self-checking testbench of the differential drive duty mixer
`timescale 1ns / 1ps
module differential_drive_duty_mixer_test;
  import ddm_pkg::*;

  localparam int RESULT_LATENCY  = 13;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int PHASE_ITEMS     = 175;
  localparam int BURST_ITEMS     = 40;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int SPARE_IDX_FIRST = REG_FLIP_RIGHT + 1;
  localparam int SPARE_IDX_LAST  = 2 ** CFG_IDX_W - 1;
  localparam int FIXED_SETTINGS  = 7;
  localparam int RANDOM_SETTINGS = 3;
  localparam int DIRECTED_ITEMS  = 12;

  typedef struct packed {
    logic signed [DUTY_W-1:0] left;
    logic signed [DUTY_W-1:0] right;
  } duty_pair_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] top;
    logic [CFG_DATA_W-1:0] floor_d;
    logic [CFG_DATA_W-1:0] gain;
    logic                  pivot;
    logic                  flip_l;
    logic                  flip_r;
  } cfg_set_t;

  class duty_scoreboard;
    logic [PCT_W-1:0] top_pct;
    logic [PCT_W-1:0] floor_pct;
    logic [PCT_W-1:0] gain_pct;
    bit               pivot_on;
    bit               rev_left;
    bit               rev_right;
    duty_pair_t       expected_duties[$];
    int               errors;
    int               checked;
    int               commands;

    function new();
      top_pct = MAX_DUTY_RST;
      floor_pct = MIN_DUTY_RST;
      gain_pct = STEER_GAIN_RST;
      pivot_on = 0;
      rev_left = 0;
      rev_right = 0;
      errors = 0;
      checked = 0;
      commands = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MAX_DUTY: top_pct = data;
        REG_MIN_DUTY: floor_pct = data;
        REG_STEER_GAIN: gain_pct = data;
        REG_PIVOT_ENABLE: pivot_on = data[0];
        REG_FLIP_LEFT: rev_left = data[0];
        REG_FLIP_RIGHT: rev_right = data[0];
        default: ;
      endcase
    endfunction

    // rounded to nearest, halves away from zero
    function int round_div(int v, int num, int den);
      int p;
      int q;
      p = v * num;
      q = ((p < 0 ? -p : p) + den / 2) / den;
      return p < 0 ? -q : q;
    endfunction

    function int compress(int cmd, int top, int floor_d);
      int m;
      int d;
      if (cmd == 0) return 0;
      m = cmd < 0 ? -cmd : cmd;
      if (m > DUTY_FULL) m = DUTY_FULL;
      d = floor_d + round_div(m, top - floor_d, DUTY_FULL);
      return cmd < 0 ? -d : d;
    endfunction

    function duty_pair_t mix_duties(logic [SPEED_W-1:0] speed, logic signed [STEER_W-1:0] steer);
      int spd;
      int str;
      int top;
      int flr;
      int gain;
      int turn;
      int l;
      int r;
      int peak;
      int mag_l;
      int mag_r;
      duty_pair_t res;
      spd = speed;
      if (spd > DUTY_FULL) spd = DUTY_FULL;
      str = int'(steer);
      if (str > DUTY_FULL) str = DUTY_FULL;
      if (str < -DUTY_FULL) str = -DUTY_FULL;
      res.left = '0;
      res.right = '0;
      if (spd == 0 && !pivot_on) return res;
      top = top_pct > DUTY_FULL ? DUTY_FULL : top_pct;
      flr = floor_pct > top ? top : floor_pct;
      gain = gain_pct > DUTY_FULL ? DUTY_FULL : gain_pct;
      turn = round_div(str, gain, DUTY_FULL);
      l = spd + turn;
      r = spd - turn;
      mag_l = l < 0 ? -l : l;
      mag_r = r < 0 ? -r : r;
      peak = mag_l > mag_r ? mag_l : mag_r;
      if (peak > DUTY_FULL) begin
        l = round_div(l, DUTY_FULL, peak);
        r = round_div(r, DUTY_FULL, peak);
      end
      l = compress(l, top, flr);
      r = compress(r, top, flr);
      if (rev_left) l = -l;
      if (rev_right) r = -r;
      res.left = l[DUTY_W-1:0];
      res.right = r[DUTY_W-1:0];
      return res;
    endfunction

    function void note_command(logic [SPEED_W-1:0] speed, logic signed [STEER_W-1:0] steer);
      expected_duties.push_back(mix_duties(speed, steer));
      commands++;
    endfunction

    function void check_duties(logic signed [DUTY_W-1:0] got_left,
                               logic signed [DUTY_W-1:0] got_right);
      duty_pair_t want;
      if (expected_duties.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending, expected none, actual left %0d right %0d",
                 $time, got_left, got_right);
        return;
      end
      want = expected_duties.pop_front();
      checked++;
      if (got_left !== want.left) begin
        errors++;
        $display("%0t: left_duty expected %0d actual %0d", $time, want.left, got_left);
      end
      if (got_right !== want.right) begin
        errors++;
        $display("%0t: right_duty expected %0d actual %0d", $time, want.right, got_right);
      end
    endfunction

    function int pending();
      return expected_duties.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   cycle_count = 0;
  int   hold_cycles;
  int   stall_left;
  bit   idle_on;
  int   settings_applied;

  duty_scoreboard sb;

  ddm_in_if  req_if ();
  ddm_out_if duty_if ();
  ddm_cfg_if reg_if ();

  differential_drive_duty_mixer uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_if),
    .out_chan (duty_if),
    .cfg_chan (reg_if)
  );

  cfg_set_t fixed_settings [FIXED_SETTINGS] = '{
    '{7'd100, 7'd0,   7'd100, 1'b0, 1'b0, 1'b0},
    '{7'd0,   7'd0,   7'd0,   1'b1, 1'b0, 1'b0},
    '{7'd127, 7'd127, 7'd127, 1'b1, 1'b1, 1'b1},
    '{7'd100, 7'd100, 7'd100, 1'b1, 1'b0, 1'b1},
    '{7'd50,  7'd20,  7'd75,  1'b1, 1'b1, 1'b0},
    '{7'd40,  7'd90,  7'd10,  1'b0, 1'b0, 1'b1},
    '{7'd1,   7'd1,   7'd1,   1'b1, 1'b1, 1'b1}
  };

  cfg_set_t directed_setting = '{7'd100, 7'd30, 7'd50, 1'b1, 1'b1, 1'b0};

  int directed_speed [DIRECTED_ITEMS] = '{0, 0, 127, 100, 101, 50, 100, 1, 100, 0, 33, 75};
  int directed_steer [DIRECTED_ITEMS] = '{0, 100, 127, -128, -101, 50, 100, -1, 1, -128, 67, -25};

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (reg_if.valid && reg_if.ready) sb.write_reg(reg_if.index, reg_if.data);
      if (duty_if.valid && duty_if.ready) sb.check_duties(duty_if.left_duty, duty_if.right_duty);
      if (req_if.valid && req_if.ready) sb.note_command(req_if.speed, req_if.steer);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [SPEED_W-1:0] pick_speed();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return '0;
    if (r < 22) return SPEED_W'($urandom_range(DUTY_FULL + 1, 2 ** SPEED_W - 1));
    if (r < 30) return SPEED_W'(DUTY_FULL);
    return SPEED_W'($urandom_range(1, DUTY_FULL));
  endfunction

  function automatic logic signed [STEER_W-1:0] pick_steer();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return STEER_W'($urandom);
    if (r < 25) return STEER_W'(DUTY_FULL);
    if (r < 30) return STEER_W'(-DUTY_FULL);
    if (r < 33) return '0;
    return STEER_W'(int'($urandom_range(0, 2 * DUTY_FULL)) - DUTY_FULL);
  endfunction

  // single-bit registers get random upper bits, which the block must ignore
  function automatic logic [CFG_DATA_W-1:0] with_noise(logic b);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom);
    d[0] = b;
    return d;
  endfunction

  // receiver: random stalls, plus a counted hold-off when asked
  initial begin
    duty_if.ready = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        duty_if.ready <= 0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        duty_if.ready <= 0;
        stall_left--;
      end else begin
        duty_if.ready <= 1;
        if (idle_on) stall_left = pick_gap();
      end
    end
  end

  task automatic send_command(logic [SPEED_W-1:0] speed_val,
                              logic signed [STEER_W-1:0] steer_val, int gap);
    if (gap > 0) begin
      req_if.valid <= 0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid <= 1;
    req_if.speed <= speed_val;
    req_if.steer <= steer_val;
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
  endtask

  task automatic write_one(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    reg_if.valid <= 1;
    reg_if.index <= idx;
    reg_if.data <= data;
    do @(posedge clk); while (!reg_if.ready);
    @(negedge clk);
  endtask

  task automatic apply_settings(cfg_set_t s);
    write_one(REG_MAX_DUTY, s.top);
    write_one(REG_MIN_DUTY, s.floor_d);
    write_one(REG_STEER_GAIN, s.gain);
    write_one(REG_PIVOT_ENABLE, with_noise(s.pivot));
    write_one(REG_FLIP_LEFT, with_noise(s.flip_l));
    write_one(REG_FLIP_RIGHT, with_noise(s.flip_r));
    // unmapped index, must not disturb anything
    write_one(CFG_IDX_W'($urandom_range(SPARE_IDX_FIRST, SPARE_IDX_LAST)), CFG_DATA_W'($urandom));
    reg_if.valid <= 0;
    settings_applied++;
  endtask

  task automatic drain();
    req_if.valid <= 0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic run_directed();
    for (int i = 0; i < DIRECTED_ITEMS; i++)
      send_command(SPEED_W'(directed_speed[i]), STEER_W'(directed_steer[i]), 0);
    drain();
  endtask

  task automatic run_random(int count, bit pause_midway);
    for (int i = 0; i < count; i++) begin
      if (pause_midway && i == count / 2) drain();
      send_command(pick_speed(), pick_steer(), idle_on ? pick_gap() : 0);
    end
    drain();
  endtask

  initial begin
    cfg_set_t s;
    sb = new();
    hold_cycles = 0;
    idle_on = 0;
    settings_applied = 0;
    rst_n = 0;
    req_if.valid = 0;
    req_if.speed = '0;
    req_if.steer = '0;
    reg_if.valid = 0;
    reg_if.index = '0;
    reg_if.data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // reset values first, then a setting with pivot, floor and one flip
    run_directed();
    apply_settings(directed_setting);
    run_directed();

    for (int p = 0; p < FIXED_SETTINGS + RANDOM_SETTINGS; p++) begin
      if (p < FIXED_SETTINGS) begin
        s = fixed_settings[p];
      end else begin
        s.top = CFG_DATA_W'($urandom);
        s.floor_d = CFG_DATA_W'($urandom);
        s.gain = CFG_DATA_W'($urandom);
        s.pivot = $urandom_range(0, 1);
        s.flip_l = $urandom_range(0, 1);
        s.flip_r = $urandom_range(0, 1);
      end
      apply_settings(s);
      idle_on = (p % 3) != 0;
      run_random(PHASE_ITEMS, p == 2);
      if (p == 4) begin
        // receiver blocked while requests keep coming, input must back up
        idle_on = 0;
        hold_cycles = HOLD_OFF_CYCLES;
        run_random(BURST_ITEMS, 0);
      end
    end

    idle_on = 0;
    drain();
    repeat (2 * RESULT_LATENCY) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
    end
    $display("run covered %0d requests and %0d checked results under %0d register settings,",
             sb.commands, sb.checked, settings_applied + 1);
    $display("with random stalls on both sides, a blocked receiver and drained pauses");
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/ddm_pkg.sv
rtl/core/ddm_ifs.sv
rtl/core/ddm_front.sv
rtl/core/ddm_queue.sv
rtl/core/ddm_back.sv
rtl/core/differential_drive_duty_mixer.sv
bench/differential_drive_duty_mixer_test.sv
